[rtl/icfmc_pkg.sv]
// Package for the IPv4 prefix classifier: codes, entry type and mask helper.
package icfmc_pkg;

    // Table depth default.
    localparam int MAX_ENTRIES_DEF = 256;

    // Address and prefix widths.
    localparam int ADDR_W = 32;
    localparam int PLEN_W = 6;
    localparam int STATUS_W = 3;
    localparam int OUT_IDX_W = 8;

    // Longest legal prefix.
    localparam logic [PLEN_W-1:0] PLEN_MAX = 6'd32;

    // Command codes.
    localparam logic CMD_APPEND = 1'b0;
    localparam logic CMD_LOOKUP = 1'b1;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_UNKNOWN    = 3'd0;
    localparam logic [STATUS_W-1:0] ST_SAFE       = 3'd1;
    localparam logic [STATUS_W-1:0] ST_SUSPICIOUS = 3'd2;
    localparam logic [STATUS_W-1:0] ST_STORED     = 3'd3;
    localparam logic [STATUS_W-1:0] ST_REJECTED   = 3'd4;

    // One stored table entry.
    typedef struct packed {
        logic [ADDR_W-1:0] base;
        logic [ADDR_W-1:0] mask;
        logic              safe;
    } entry_t;

    // Prefix length to network mask; lengths of 32 give all ones.
    function automatic logic [ADDR_W-1:0] prefix_mask(input logic [PLEN_W-1:0] plen);
        logic [ADDR_W-1:0] ones;
        ones = {ADDR_W{1'b1}};
        return ~(ones >> plen);
    endfunction

endpackage

[rtl/ipv4_cidr_first_match_classifier_top.sv]
// Top level of the IPv4 first-match prefix classifier with its scan sequencer.
//
//  channel | signals                                       | role
//  --------+-----------------------------------------------+------------------------------
//  in      | in_valid, in_ready, command, address,         | append an entry or look up
//          | prefix_len, is_safe                           | an address
//  out     | out_valid, out_ready, status, entry_index     | one result per input transfer
//
// An append, or a lookup on an empty table, goes from its transfer straight to the
// finish state with its result held in the result registers.
// A lookup examines the stored entries in order from entry 0 until the first match
// or the last stored entry, one entry at a time, paced by the single read port of the entry
// memory and the one masked compare unit.
// Reset empties the table through the entry count alone; the memory is not cleared.
// The input stays ready while a result waits, and a finished item holds in the
// finish state until the output register is free.
module ipv4_cidr_first_match_classifier_top #(
    parameter int MAX_ENTRIES = icfmc_pkg::MAX_ENTRIES_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic                              command,
    input  logic [icfmc_pkg::ADDR_W-1:0]      address,
    input  logic [icfmc_pkg::PLEN_W-1:0]      prefix_len,
    input  logic                              is_safe,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [icfmc_pkg::STATUS_W-1:0]    status,
    output logic [icfmc_pkg::OUT_IDX_W-1:0]   entry_index
);
    import icfmc_pkg::*;

    localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

    // Sequencer states.
    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SCAN   = 2'd1;
    localparam logic [1:0] S_FINISH = 2'd2;

    logic [1:0]          state_reg, state_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [IDX_W-1:0]    scan_idx_reg, scan_idx_next;
    logic [ADDR_W-1:0]   query_reg, query_next;
    logic [STATUS_W-1:0] res_status_reg, res_status_next;
    logic [IDX_W-1:0]    res_index_reg, res_index_next;
    logic                out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic [OUT_IDX_W-1:0] entry_index_reg, entry_index_next;

    logic                in_xfer;
    logic                table_full;
    logic                append_ok;
    logic                scan_hit;
    logic                scan_last;
    logic                wr_en;
    logic                rd_en;
    logic [IDX_W-1:0]    rd_addr;
    entry_t              wr_data;
    entry_t              rd_data;
    logic [IDX_W+OUT_IDX_W-1:0] index_wide;

    icfmc_table #(
        .DEPTH (MAX_ENTRIES),
        .IDX_W (IDX_W)
    ) u_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (count_reg[IDX_W-1:0]),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign in_ready   = (state_reg == S_IDLE);
    assign in_xfer    = in_valid && in_ready;
    assign table_full = (count_reg == CNT_W'(MAX_ENTRIES));
    assign append_ok  = (prefix_len <= PLEN_MAX) && !table_full;

    // New entry: mask from the prefix length, host bits of the base cleared.
    always_comb
    begin
        wr_data.mask = prefix_mask(prefix_len);
        wr_data.base = address & prefix_mask(prefix_len);
        wr_data.safe = is_safe;
    end
    assign wr_en = in_xfer && (command == CMD_APPEND) && append_ok;

    // Shared compare unit on the entry just read, and end-of-table test.
    assign scan_hit  = ((query_reg & rd_data.mask) == rd_data.base);
    assign scan_last = ((CNT_W'(scan_idx_reg) + CNT_W'(1)) == count_reg);

    // Low bits of the result index go to the port.
    assign index_wide = {{OUT_IDX_W{1'b0}}, res_index_reg};

    // Sequencer and read address control.
    always_comb
    begin
        state_next       = state_reg;
        count_next       = count_reg;
        scan_idx_next    = scan_idx_reg;
        query_next       = query_reg;
        res_status_next  = res_status_reg;
        res_index_next   = res_index_reg;
        out_valid_next   = out_valid_reg;
        status_next      = status_reg;
        entry_index_next = entry_index_reg;
        rd_en            = 1'b0;
        rd_addr          = '0;

        // Output register empties on a transfer.
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    state_next     = S_FINISH;
                    res_index_next = '0;
                    if (command == CMD_APPEND)
                    begin
                        if (append_ok)
                        begin
                            res_status_next = ST_STORED;
                            res_index_next  = count_reg[IDX_W-1:0];
                            count_next      = count_reg + CNT_W'(1);
                        end
                        else
                        begin
                            res_status_next = ST_REJECTED;
                        end
                    end
                    else
                    begin
                        res_status_next = ST_UNKNOWN;
                        query_next      = address;
                        if (count_reg != '0)
                        begin
                            state_next    = S_SCAN;
                            scan_idx_next = '0;
                            rd_en         = 1'b1;
                        end
                    end
                end
            end

            S_SCAN:
            begin
                if (scan_hit)
                begin
                    state_next      = S_FINISH;
                    res_status_next = rd_data.safe ? ST_SAFE : ST_SUSPICIOUS;
                    res_index_next  = scan_idx_reg;
                end
                else if (scan_last)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    // Fetch the next entry while this one is compared.
                    rd_en         = 1'b1;
                    rd_addr       = scan_idx_reg + IDX_W'(1);
                    scan_idx_next = scan_idx_reg + IDX_W'(1);
                end
            end

            S_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next   = 1'b1;
                    status_next      = res_status_reg;
                    entry_index_next = index_wide[OUT_IDX_W-1:0];
                    state_next       = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        scan_idx_reg    <= scan_idx_next;
        query_reg       <= query_next;
        res_status_reg  <= res_status_next;
        res_index_reg   <= res_index_next;
        status_reg      <= status_next;
        entry_index_reg <= entry_index_next;
    end

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign entry_index = entry_index_reg;

`ifndef SYNTHESIS
    // A stored append grows the table by exactly one entry.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && (command == CMD_APPEND) && (prefix_len <= PLEN_MAX)
            && !table_full)
        |=> (count_reg == $past(count_reg) + CNT_W'(1)))
    else $error("entry count did not advance on a stored append");

    // Without an append transfer the table size holds.
    assert property (@(posedge clk) disable iff (!rst_n)
        !(in_valid && in_ready && (command == CMD_APPEND)) |=> $stable(count_reg))
    else $error("entry count changed without an append");

    // The table never grows beyond its depth.
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_ENTRIES))
    else $error("entry count above table depth");

    // A scan only runs over stored entries.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> (CNT_W'(scan_idx_reg) < count_reg))
    else $error("scan index beyond stored entries");
`endif

endmodule

[rtl/icfmc_table.sv]
// Entry memory of the classifier: one write port, one registered read port.
module icfmc_table #(
    parameter int DEPTH = icfmc_pkg::MAX_ENTRIES_DEF,
    parameter int IDX_W = 8
) (
    input  logic                 clk,
    input  logic                 wr_en,
    input  logic [IDX_W-1:0]     wr_addr,
    input  icfmc_pkg::entry_t    wr_data,
    input  logic                 rd_en,
    input  logic [IDX_W-1:0]     rd_addr,
    output icfmc_pkg::entry_t    rd_data
);
    import icfmc_pkg::*;

    entry_t mem [DEPTH];
    entry_t rd_data_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
